@@ rtl/core/dbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dbd_pkg;

  // Field widths of one item.
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DIFF_W  = 23;

  // Day numbers up to 9999-12-31 fit in 22 bits.
  localparam int unsigned DNUM_W = 22;
  // Quotient of a 14-bit year by 100.
  localparam int unsigned QUOT_W = 8;
  // Remainder by 100.
  localparam int unsigned REM_W  = 7;
  // Days before the first of a month.
  localparam int unsigned CUM_W  = 9;

  localparam logic [YEAR_W-1:0]  YEAR_MAX     = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN    = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC    = MONTH_W'(12);
  localparam logic [8:0]         DAYS_IN_YEAR = 9'd365;
  localparam logic [6:0]         CENTURY      = 7'd100;

  // Reciprocal of 100 scaled by 2^19; exact for every 14-bit dividend.
  localparam logic [12:0]        RECIP_100    = 13'd5243;
  localparam int unsigned        RECIP_SHIFT  = 19;

  // Command group from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic sum;
    logic result;
  } dbd_cmd_t;

  // Length of a month in days, zero for a month code that means nothing.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
        4'd2:                                        len = leap ? 5'd29 : 5'd28;
        default:                                     len = 5'd0;
      endcase
      return len;
    end
  endfunction

  // Days in a common year before the first of the month.
  function automatic logic [CUM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [CUM_W-1:0] n;
    begin
      case (m)
        4'd2:    n = 9'd31;
        4'd3:    n = 9'd59;
        4'd4:    n = 9'd90;
        4'd5:    n = 9'd120;
        4'd6:    n = 9'd151;
        4'd7:    n = 9'd181;
        4'd8:    n = 9'd212;
        4'd9:    n = 9'd243;
        4'd10:   n = 9'd273;
        4'd11:   n = 9'd304;
        4'd12:   n = 9'd334;
        default: n = 9'd0;
      endcase
      return n;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dbd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dbd_ctrl
  import dbd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_stall_o,
  output      logic     out_valid_o,
  input  wire logic     out_stall_i,
  output      dbd_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  // The output register may be loaded when it is empty or being drained.
  assign load = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);

  // Next state and output valid.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (load) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Commands to the datapath.
  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.mul      = (state_q == ST_MUL);
  assign cmd_o.sum      = (state_q == ST_SUM);
  assign cmd_o.result   = load;

endmodule

`default_nettype wire

@@ rtl/core/dbd_daynum.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dbd_daynum
  import dbd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               mul_i,
  input  wire logic               sum_i,
  input  wire logic [YEAR_W-1:0]  year_i,
  input  wire logic [MONTH_W-1:0] month_i,
  input  wire logic [DAY_W-1:0]   day_i,
  output      logic [DNUM_W-1:0]  dnum_o,
  output      logic               ok_o
);

  logic [YEAR_W-1:0]          prev_year;
  logic [YEAR_W+8:0]          p365_full;
  logic [YEAR_W+12:0]         qp_full;
  logic [YEAR_W+12:0]         qy_full;
  logic [DNUM_W-1:0]          p365_q;
  logic [QUOT_W-1:0]          qp_q;
  logic [QUOT_W-1:0]          qy_q;
  logic [YEAR_W-1:0]          cent_mul;
  logic [YEAR_W-1:0]          rem_full;
  logic [REM_W-1:0]           rem100;
  logic                       leap;
  logic                       year_ok;
  logic                       day_ok;
  logic [DAY_W-1:0]           len;
  logic [DNUM_W-1:0]          dnum_d;
  logic [DNUM_W-1:0]          dnum_q;
  logic                       ok_q;

  assign prev_year = year_i - YEAR_W'(1);

  // First step: whole years times 365, and both years divided by 100.
  assign p365_full = prev_year * DAYS_IN_YEAR;
  assign qp_full   = prev_year * RECIP_100;
  assign qy_full   = year_i * RECIP_100;

  always_ff @(posedge clk_i) begin
    if (mul_i) begin
      p365_q <= p365_full[DNUM_W-1:0];
      qp_q   <= QUOT_W'(qp_full >> RECIP_SHIFT);
      qy_q   <= QUOT_W'(qy_full >> RECIP_SHIFT);
    end
  end

  // Second step: leap rule, validity and the day number.
  assign cent_mul = YEAR_W'(qy_q) * YEAR_W'(CENTURY);
  assign rem_full = year_i - cent_mul;
  assign rem100   = rem_full[REM_W-1:0];
  assign leap     = (year_i[1:0] == 2'b00 && rem100 != '0) ||
                    (rem100 == '0 && qy_q[1:0] == 2'b00);
  assign year_ok  = (year_i != '0) && (year_i <= YEAR_MAX);
  assign len      = month_len(month_i, leap);
  assign day_ok   = (day_i != '0) && (day_i <= len);

  always_comb begin
    dnum_d = p365_q
           + DNUM_W'(prev_year >> 2)
           - DNUM_W'(qp_q)
           + DNUM_W'(qp_q >> 2)
           + DNUM_W'(days_before(month_i))
           + DNUM_W'(day_i);
    if (leap && month_i > MONTH_FEB) begin
      dnum_d = dnum_d + DNUM_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_i) begin
      dnum_q <= dnum_d;
      ok_q   <= year_ok && (month_i >= MONTH_JAN) && (month_i <= MONTH_DEC) && day_ok;
    end
  end

  assign dnum_o = dnum_q;
  assign ok_o   = ok_q;

endmodule

`default_nettype wire

@@ rtl/core/dbd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dbd_datapath
  import dbd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire dbd_cmd_t                 cmd_i,
  input  wire logic [YEAR_W-1:0]        first_year_i,
  input  wire logic [MONTH_W-1:0]       first_month_i,
  input  wire logic [DAY_W-1:0]         first_day_i,
  input  wire logic [YEAR_W-1:0]        second_year_i,
  input  wire logic [MONTH_W-1:0]       second_month_i,
  input  wire logic [DAY_W-1:0]         second_day_i,
  output      logic signed [DIFF_W-1:0] day_difference_o,
  output      logic                     bad_date_o
);

  logic [YEAR_W-1:0]         y1_q, y2_q;
  logic [MONTH_W-1:0]        m1_q, m2_q;
  logic [DAY_W-1:0]          d1_q, d2_q;
  logic [DNUM_W-1:0]         n1, n2;
  logic                      ok1, ok2;
  logic [DIFF_W-1:0]         diff;
  logic signed [DIFF_W-1:0]  diff_q;
  logic                      bad_q;

  // Input capture; held for the whole item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      y1_q <= first_year_i;
      m1_q <= first_month_i;
      d1_q <= first_day_i;
      y2_q <= second_year_i;
      m2_q <= second_month_i;
      d2_q <= second_day_i;
    end
  end

  dbd_daynum u_first (
    .clk_i   (clk_i),
    .mul_i   (cmd_i.mul),
    .sum_i   (cmd_i.sum),
    .year_i  (y1_q),
    .month_i (m1_q),
    .day_i   (d1_q),
    .dnum_o  (n1),
    .ok_o    (ok1)
  );

  dbd_daynum u_second (
    .clk_i   (clk_i),
    .mul_i   (cmd_i.mul),
    .sum_i   (cmd_i.sum),
    .year_i  (y2_q),
    .month_i (m2_q),
    .day_i   (d2_q),
    .dnum_o  (n2),
    .ok_o    (ok2)
  );

  // Difference of day numbers, forced to zero for an invalid date.
  assign diff = {1'b0, n1} - {1'b0, n2};

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      bad_q  <= !(ok1 && ok2);
      diff_q <= (ok1 && ok2) ? $signed(diff) : '0;
    end
  end

  assign day_difference_o = diff_q;
  assign bad_date_o       = bad_q;

endmodule

`default_nettype wire

@@ rtl/core/days_between_dates_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Signed day count between two Gregorian dates: day_difference_o is the first
// date minus the second, in days, with bad_date_o set and a zero difference when
// either date has a year outside 1..9999, a month outside 1..12 or a day outside
// its month. The block works on one item at a time: after it takes an item it
// does the multiplies by 365 and by the reciprocal of 100, then the leap rule
// and the day-number sum, then the subtraction, which loads the result into
// the output register; no new item is accepted before that load. The result
// waits in the output register, and the next item is accepted while it waits;
// that item then holds in its last step until the output register is drained.
module days_between_dates_core
  import dbd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_stall_o,
  input  wire logic [YEAR_W-1:0]        first_year_i,
  input  wire logic [MONTH_W-1:0]       first_month_i,
  input  wire logic [DAY_W-1:0]         first_day_i,
  input  wire logic [YEAR_W-1:0]        second_year_i,
  input  wire logic [MONTH_W-1:0]       second_month_i,
  input  wire logic [DAY_W-1:0]         second_day_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  output      logic signed [DIFF_W-1:0] day_difference_o,
  output      logic                     bad_date_o
);

  dbd_cmd_t cmd;

  dbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  dbd_datapath u_datapath (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .first_year_i     (first_year_i),
    .first_month_i    (first_month_i),
    .first_day_i      (first_day_i),
    .second_year_i    (second_year_i),
    .second_month_i   (second_month_i),
    .second_day_i     (second_day_i),
    .day_difference_o (day_difference_o),
    .bad_date_o       (bad_date_o)
  );

endmodule

`default_nettype wire
